// File: rtl/ecn_pkg.sv
// ----------------------------------------------------------------------------
// ecn_pkg
// Shared types and constants of the event and condition notifier: command
// codes, the queued command, the result transaction and default sizes.
// ----------------------------------------------------------------------------
package ecn_pkg;

   localparam int WORD_BITS           = 64;
   localparam int ID_W                = 8;
   localparam int RELOAD_W            = 8;
   localparam int MASK_WORDS_DEF      = 4;
   localparam int CONDITION_LIMIT_DEF = 256;
   localparam int EVENT_LIMIT_DEF     = 64;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [RELOAD_W-1:0] RELOAD_RESET = 8'd4;

   typedef enum logic [2:0] {
      CMD_EVENT   = 3'd0,
      CMD_SET     = 3'd1,
      CMD_CANCEL  = 3'd2,
      CMD_TICK    = 3'd3,
      CMD_PUBLISH = 3'd4
   } cmd_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_PUB
   } back_state_type;

   typedef struct packed {
      cmd_type         cmd;
      logic [ID_W-1:0] id;
   } op_type;

   typedef struct packed {
      logic                 kind;
      logic [5:0]           event_id;
      logic [1:0]           word_index;
      logic [WORD_BITS-1:0] active_word;
      logic [WORD_BITS-1:0] valid_word;
      logic                 last;
   } rsp_type;

endpackage

// File: rtl/ecn_fifo.sv
// ----------------------------------------------------------------------------
// ecn_fifo
// Small first-in first-out queue with full/empty flags; decouples the
// command front end from the back end and the back end from the result port.
// ----------------------------------------------------------------------------
module ecn_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/ecn_front.sv
// ----------------------------------------------------------------------------
// ecn_front
// Command classifier: checks the command code and the id range and forwards
// only commands that have an effect to the command queue.
// ----------------------------------------------------------------------------
module ecn_front #(
   parameter int MASK_WORDS      = ecn_pkg::MASK_WORDS_DEF,
   parameter int CONDITION_LIMIT = ecn_pkg::CONDITION_LIMIT_DEF,
   parameter int EVENT_LIMIT     = ecn_pkg::EVENT_LIMIT_DEF
) (
   input  logic                    req_push,
   input  logic [2:0]              req_command,
   input  logic [ecn_pkg::ID_W-1:0] req_id,
   input  logic                    queue_full,
   output logic                    op_push,
   output ecn_pkg::op_type         op
);
   import ecn_pkg::*;

   logic keep;

   always_comb begin
      keep = 1'b0;
      case (req_command)
         CMD_EVENT: begin
            keep = (req_id != '0) && (int'(req_id) < EVENT_LIMIT)
                   && (int'(req_id) < WORD_BITS);
         end
         CMD_SET, CMD_CANCEL: begin
            keep = (req_id != '0) && (int'(req_id) < CONDITION_LIMIT)
                   && (int'(req_id[7:6]) < MASK_WORDS);
         end
         CMD_TICK, CMD_PUBLISH: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // drop ignored commands here; they never reach the back end
   assign op_push = req_push && !queue_full && keep;
   assign op.cmd  = cmd_type'(req_command);
   assign op.id   = req_id;

endmodule

// File: rtl/ecn_back.sv
// ----------------------------------------------------------------------------
// ecn_back
// Execution engine: holds the sent-mask, condition masks, reported copy and
// tick counter, and sequences publish bursts one word per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module ecn_back #(
   parameter int MASK_WORDS = ecn_pkg::MASK_WORDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [ecn_pkg::RELOAD_W-1:0] csr_data,
   input  logic                        cmd_empty,
   input  ecn_pkg::op_type             cmd,
   output logic                        cmd_pop,
   input  logic                        rsp_full,
   output logic                        rsp_push,
   output ecn_pkg::rsp_type            rsp_data
);
   import ecn_pkg::*;

   localparam int CNT_W = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;

   back_state_type       state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] sent_ff, sent_in;
   logic [WORD_BITS-1:0] active_ff   [MASK_WORDS];
   logic [WORD_BITS-1:0] active_in   [MASK_WORDS];
   logic [WORD_BITS-1:0] valid_ff    [MASK_WORDS];
   logic [WORD_BITS-1:0] valid_in    [MASK_WORDS];
   logic [WORD_BITS-1:0] reported_ff [MASK_WORDS];
   logic [WORD_BITS-1:0] reported_in [MASK_WORDS];
   logic [RELOAD_W-1:0]  tick_ff, tick_in;
   logic [RELOAD_W-1:0]  reload_ff;
   logic                 changed;
   logic                 last_word;

   always_comb begin
      changed = 1'b0;
      for (int w = 0; w < MASK_WORDS; w++) begin
         changed = changed | (active_ff[w] != reported_ff[w]);
      end
   end

   assign last_word = (cnt_ff == CNT_W'(MASK_WORDS-1));

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      sent_in     = sent_ff;
      active_in   = active_ff;
      valid_in    = valid_ff;
      reported_in = reported_ff;
      tick_in     = tick_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp_data    = '0;
      case (state_ff)
         BACK_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               case (cmd.cmd)
                  CMD_EVENT: begin
                     if (!sent_ff[cmd.id[5:0]]) begin
                        rsp_push          = 1'b1;
                        rsp_data.event_id = cmd.id[5:0];
                        rsp_data.last     = 1'b1;
                        sent_in[cmd.id[5:0]] = 1'b1;
                     end
                  end
                  CMD_SET, CMD_CANCEL: begin
                     for (int w = 0; w < MASK_WORDS; w++) begin
                        if (int'(cmd.id[7:6]) == w) begin
                           active_in[w][cmd.id[5:0]] = (cmd.cmd == CMD_SET);
                           valid_in[w][cmd.id[5:0]]  = 1'b1;
                        end
                     end
                  end
                  CMD_TICK: begin
                     if (changed) begin
                        state_in = BACK_PUB;
                        cnt_in   = '0;
                     end
                     // counter hitting zero reopens every event
                     if (tick_ff == '0) begin
                        sent_in = '0;
                        tick_in = reload_ff;
                     end else begin
                        tick_in = tick_ff - 1'b1;
                     end
                  end
                  CMD_PUBLISH: begin
                     state_in = BACK_PUB;
                     cnt_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BACK_PUB: begin
            if (!rsp_full) begin
               rsp_push             = 1'b1;
               rsp_data.kind        = 1'b1;
               rsp_data.word_index  = 2'(cnt_ff);
               rsp_data.active_word = active_ff[cnt_ff];
               rsp_data.valid_word  = valid_ff[cnt_ff];
               rsp_data.last        = last_word;
               for (int w = 0; w < MASK_WORDS; w++) begin
                  if (int'(cnt_ff) == w) begin
                     reported_in[w] = active_ff[w];
                  end
               end
               if (last_word) begin
                  state_in = BACK_IDLE;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BACK_IDLE;
         cnt_ff    <= '0;
         sent_ff   <= '0;
         tick_ff   <= RELOAD_RESET;
         reload_ff <= RELOAD_RESET;
         for (int w = 0; w < MASK_WORDS; w++) begin
            active_ff[w]   <= '0;
            valid_ff[w]    <= '0;
            reported_ff[w] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         sent_ff     <= sent_in;
         tick_ff     <= tick_in;
         active_ff   <= active_in;
         valid_ff    <= valid_in;
         reported_ff <= reported_in;
         if (csr_we) begin
            reload_ff <= csr_data;
         end
      end
   end

endmodule

// File: rtl/event_and_condition_notifier_top.sv
// ----------------------------------------------------------------------------
// event_and_condition_notifier_top
// Event and condition notifier with queue-style command and result ports.
// ----------------------------------------------------------------------------
// Commands enter at one per cycle while req_full is low; commands that have
// no effect (bad id, unused code) are dropped at the front. The back end
// executes one queued command per cycle while idle and while the result queue
// has room; a tick that publishes or a forced publish runs the burst
// sequencer, which emits one mask word per cycle into the two-entry result
// queue while it has room. Result backpressure stalls the back end, and the
// command queue then fills and raises req_full.
module event_and_condition_notifier_top #(
   parameter int MASK_WORDS      = ecn_pkg::MASK_WORDS_DEF,
   parameter int CONDITION_LIMIT = ecn_pkg::CONDITION_LIMIT_DEF,
   parameter int EVENT_LIMIT     = ecn_pkg::EVENT_LIMIT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [2:0]                       req_command,
   input  logic [ecn_pkg::ID_W-1:0]         req_id,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic                             rsp_kind,
   output logic [5:0]                       rsp_event_id,
   output logic [1:0]                       rsp_word_index,
   output logic [ecn_pkg::WORD_BITS-1:0]    rsp_active_word,
   output logic [ecn_pkg::WORD_BITS-1:0]    rsp_valid_word,
   output logic                             rsp_last,
   input  logic                             csr_we,
   input  logic [ecn_pkg::RELOAD_W-1:0]     csr_data
);
   import ecn_pkg::*;

   op_type  front_op, back_op;
   logic    front_push, cmd_full, cmd_empty, cmd_pop;
   rsp_type back_rsp, out_rsp;
   logic    back_push, out_full;

   ecn_front #(
      .MASK_WORDS      (MASK_WORDS),
      .CONDITION_LIMIT (CONDITION_LIMIT),
      .EVENT_LIMIT     (EVENT_LIMIT)
   ) u_front (
      .req_push    (req_push),
      .req_command (req_command),
      .req_id      (req_id),
      .queue_full  (cmd_full),
      .op_push     (front_push),
      .op          (front_op)
   );

   ecn_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_op),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (back_op),
      .empty     (cmd_empty)
   );

   ecn_back #(
      .MASK_WORDS (MASK_WORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_data  (csr_data),
      .cmd_empty (cmd_empty),
      .cmd       (back_op),
      .cmd_pop   (cmd_pop),
      .rsp_full  (out_full),
      .rsp_push  (back_push),
      .rsp_data  (back_rsp)
   );

   ecn_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_rsp),
      .empty     (rsp_empty)
   );

   assign req_full        = cmd_full;
   assign rsp_kind        = out_rsp.kind;
   assign rsp_event_id    = out_rsp.event_id;
   assign rsp_word_index  = out_rsp.word_index;
   assign rsp_active_word = out_rsp.active_word;
   assign rsp_valid_word  = out_rsp.valid_word;
   assign rsp_last        = out_rsp.last;

endmodule

// File: rtl/ecn_checker.sv
// ----------------------------------------------------------------------------
// ecn_checker
// Port-level checks of the notifier: reset state, event transaction shape,
// unbroken publish bursts and result stability.
// ----------------------------------------------------------------------------
module ecn_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic                          rsp_kind,
   input logic [5:0]                    rsp_event_id,
   input logic [ecn_pkg::WORD_BITS-1:0] rsp_active_word,
   input logic                          rsp_last
);
   import ecn_pkg::*;

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // event transaction: single beat, nonzero id, no mask payload
   a_event_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_kind) |-> (rsp_last && rsp_event_id != '0
                                     && rsp_active_word == '0))
      else $error("malformed event transaction");

   // a publish burst is never interleaved with an event
   a_burst_whole: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && rsp_kind && !rsp_last) |=> (rsp_empty || rsp_kind))
      else $error("publish burst broken by another transaction");

   // a waiting result does not vanish without a pop
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("result dropped without pop");

endmodule

bind event_and_condition_notifier_top ecn_checker u_ecn_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_kind        (rsp_kind),
   .rsp_event_id    (rsp_event_id),
   .rsp_active_word (rsp_active_word),
   .rsp_last        (rsp_last)
);
